// ===== src/rme_pkg.sv =====
// Shared constants, register codes, state codes and control structs for the modexp core.
package rme_pkg;

    // Default arithmetic width and fixed port widths.
    localparam int DEF_WIDTH = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;

    // Register indexes on the configuration port (byte address 4*index).
    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_PUB_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIV_EXP = 2'd2;

    // Register reset values.
    localparam logic [DATA_W-1:0] MODULUS_RST  = 32'd2;
    localparam logic [DATA_W-1:0] PUB_EXP_RST  = 32'd65537;
    localparam logic [DATA_W-1:0] PRIV_EXP_RST = 32'd1;

    // Operation selector values.
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RED   = 5'b00010,
        S_PLOAD = 5'b00100,
        S_PSTEP = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic red_step;
        logic red_last;
        logic p_load;
        logic p_step;
        logic p_last;
        logic sel_sq;
        logic e_shift;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exp_bit;
    } t_status;

endpackage

// ===== src/rme_datapath.sv =====
// Datapath of the modexp core: input reduction, shift-add modular product and result register.
module rme_datapath #(
    parameter int WIDTH = rme_pkg::DEF_WIDTH
) (
    input  logic                        i_clk,
    input  rme_pkg::t_cmd               i_cmd,
    output rme_pkg::t_status            o_status,
    input  logic                        i_func,
    input  logic [rme_pkg::DATA_W-1:0]  i_message,
    input  logic [rme_pkg::DATA_W-1:0]  i_modulus,
    input  logic [rme_pkg::DATA_W-1:0]  i_pub_exp,
    input  logic [rme_pkg::DATA_W-1:0]  i_priv_exp,
    output logic [rme_pkg::DATA_W-1:0]  o_result_value
);
    import rme_pkg::*;

    localparam int W = WIDTH;

    // Port values brought to the arithmetic width.
    logic [W-1:0] w_mod;
    logic [W-1:0] w_msg;
    logic [W-1:0] w_pub;
    logic [W-1:0] w_priv;

    logic [W-1:0] r_n,    n_n;
    logic [W-1:0] r_exp,  n_exp;
    logic [W-1:0] r_msg,  n_msg;
    logic [W-1:0] r_rem,  n_rem;
    logic [W-1:0] r_base, n_base;
    logic [W-1:0] r_acc,  n_acc;
    logic [W-1:0] r_pa,   n_pa;
    logic [W-1:0] r_pb,   n_pb;
    logic [W-1:0] r_pacc, n_pacc;
    logic [W-1:0] r_result, n_result;

    logic [W:0]   w_rem_shift;
    logic [W:0]   w_rem_sub;
    logic [W-1:0] w_rem_nxt;
    logic [W:0]   w_sum;
    logic [W:0]   w_sum_sub;
    logic [W-1:0] w_pacc_nxt;
    logic [W:0]   w_dbl;
    logic [W:0]   w_dbl_sub;
    logic [W-1:0] w_pa_nxt;
    logic [W:0]   w_n_ext;

    // Width adaptation: values are taken in their low WIDTH bits.
    generate
        if (W > DATA_W) begin : g_wide
            assign w_mod          = {{(W-DATA_W){1'b0}}, i_modulus};
            assign w_msg          = {{(W-DATA_W){1'b0}}, i_message};
            assign w_pub          = {{(W-DATA_W){1'b0}}, i_pub_exp};
            assign w_priv         = {{(W-DATA_W){1'b0}}, i_priv_exp};
            assign o_result_value = r_result[DATA_W-1:0];
        end else if (W == DATA_W) begin : g_equal
            assign w_mod          = i_modulus;
            assign w_msg          = i_message;
            assign w_pub          = i_pub_exp;
            assign w_priv         = i_priv_exp;
            assign o_result_value = r_result;
        end else begin : g_narrow
            assign w_mod          = i_modulus[W-1:0];
            assign w_msg          = i_message[W-1:0];
            assign w_pub          = i_pub_exp[W-1:0];
            assign w_priv         = i_priv_exp[W-1:0];
            assign o_result_value = {{(DATA_W-W){1'b0}}, r_result};
        end
    endgenerate

    assign w_n_ext = {1'b0, r_n};

    // Restoring remainder step: shift in the next message bit, subtract n if it fits.
    assign w_rem_shift = {r_rem, r_msg[W-1]};
    assign w_rem_sub   = w_rem_shift - w_n_ext;
    assign w_rem_nxt   = (w_rem_shift >= w_n_ext) ? w_rem_sub[W-1:0] : w_rem_shift[W-1:0];

    // Product step: conditional add of the multiplicand, then doubling, each reduced once.
    assign w_sum      = {1'b0, r_pacc} + {1'b0, r_pa};
    assign w_sum_sub  = w_sum - w_n_ext;
    assign w_pacc_nxt = r_pb[0] ? ((w_sum >= w_n_ext) ? w_sum_sub[W-1:0] : w_sum[W-1:0])
                                : r_pacc;
    assign w_dbl      = {r_pa, 1'b0};
    assign w_dbl_sub  = w_dbl - w_n_ext;
    assign w_pa_nxt   = (w_dbl >= w_n_ext) ? w_dbl_sub[W-1:0] : w_dbl[W-1:0];

    assign o_status.exp_bit = r_exp[0];

    // Next-value logic driven by the controller's commands.
    always_comb begin
        n_n      = r_n;
        n_exp    = r_exp;
        n_msg    = r_msg;
        n_rem    = r_rem;
        n_base   = r_base;
        n_acc    = r_acc;
        n_pa     = r_pa;
        n_pb     = r_pb;
        n_pacc   = r_pacc;
        n_result = r_result;

        if (i_cmd.load) begin
            n_n   = w_mod;
            n_exp = (i_func == FUNC_DECRYPT) ? w_priv : w_pub;
            n_msg = w_msg;
            n_rem = '0;
        end

        if (i_cmd.red_step) begin
            n_rem = w_rem_nxt;
            n_msg = r_msg << 1;
            if (i_cmd.red_last) begin
                n_base = w_rem_nxt;
                n_acc  = {{(W-1){1'b0}}, 1'b1};
            end
        end

        if (i_cmd.p_load) begin
            n_pa   = i_cmd.sel_sq ? r_base : r_acc;
            n_pb   = r_base;
            n_pacc = '0;
        end

        if (i_cmd.p_step) begin
            n_pacc = w_pacc_nxt;
            n_pa   = w_pa_nxt;
            n_pb   = r_pb >> 1;
            if (i_cmd.p_last) begin
                if (i_cmd.sel_sq) begin
                    n_base = w_pacc_nxt;
                end else begin
                    n_acc = w_pacc_nxt;
                end
            end
        end

        if (i_cmd.e_shift) begin
            n_exp = r_exp >> 1;
        end

        // A modulus of zero or one has no meaningful residue.
        if (i_cmd.out_load) begin
            n_result = (r_n < {{(W-2){1'b0}}, 2'b10}) ? '0 : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_exp    <= n_exp;
        r_msg    <= n_msg;
        r_rem    <= n_rem;
        r_base   <= n_base;
        r_acc    <= n_acc;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_pacc   <= n_pacc;
        r_result <= n_result;
    end

endmodule

// ===== src/rme_controller.sv =====
// Controller of the modexp core: sequences reduction, multiplies and squares, and the output word.
module rme_controller #(
    parameter int WIDTH = rme_pkg::DEF_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  rme_pkg::t_status  i_status,
    output rme_pkg::t_cmd     o_cmd
);
    import rme_pkg::*;

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [CW-1:0] r_ebit,  n_ebit;
    logic          r_sq,    n_sq;
    logic          r_ov,    n_ov;
    logic          w_sq_now;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;

    // At the start of an exponent bit, a clear bit skips straight to the square.
    assign w_sq_now = r_sq | ~i_status.exp_bit;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ebit  = r_ebit;
        n_sq    = r_sq;
        o_cmd   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                o_cmd.red_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    o_cmd.red_last = 1'b1;
                    n_ebit         = '0;
                    n_sq           = 1'b0;
                    n_state        = S_PLOAD;
                end
            end
            S_PLOAD: begin
                o_cmd.p_load = 1'b1;
                o_cmd.sel_sq = w_sq_now;
                n_sq         = w_sq_now;
                n_cnt        = '0;
                n_state      = S_PSTEP;
            end
            S_PSTEP: begin
                o_cmd.p_step = 1'b1;
                o_cmd.sel_sq = r_sq;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    o_cmd.p_last = 1'b1;
                    if (!r_sq) begin
                        // Multiply done; the square of this bit follows.
                        n_sq    = 1'b1;
                        n_state = S_PLOAD;
                    end else begin
                        o_cmd.e_shift = 1'b1;
                        n_sq          = 1'b0;
                        n_ebit        = r_ebit + 1'b1;
                        n_state       = (r_ebit == LAST) ? S_FIN : S_PLOAD;
                    end
                end
            end
            S_FIN: begin
                // Hold until the output register is free.
                if (!r_ov || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb begin
        n_ov = r_ov;
        if (o_cmd.out_load) begin
            n_ov = 1'b1;
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ebit  <= '0;
            r_sq    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ebit  <= n_ebit;
            r_sq    <= n_sq;
            r_ov    <= n_ov;
        end
    end

endmodule

// ===== src/rsa_modular_exponentiation_core.sv =====
// Top level of the RSA modular exponentiation core: register port, controller and datapath.
//
// Usage: program modulus (0x0), public exponent (0x4) and private exponent (0x8)
// through the APB-style port while the core is idle; reads return the stored values.
// Each input word carries i_func (0 encrypt with the public exponent, 1 decrypt
// with the private one) and i_message. It is taken when i_in_valid is high and
// o_in_stall is low. The result word appears on o_result_value with o_out_valid
// and is taken when i_out_stall is low.
// Operation: one word is first reduced modulo n, then each exponent bit costs one
// modular square and, for a set bit, one modular multiply, all on the single
// shift-add product unit. One word is in work at a time.
// A finished result waits in the output register while the next word is accepted;
// if the receiver still stalls when that next result is ready, the core holds it.
// Reset clears the handshake state and restores the register reset values.
// A modulus of zero or one yields a result of zero.
module rsa_modular_exponentiation_core #(
    parameter int WIDTH = rme_pkg::DEF_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [rme_pkg::DATA_W-1:0]  i_message,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rme_pkg::DATA_W-1:0]  o_result_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rme_pkg::ADDR_W-1:0]  paddr,
    input  logic [rme_pkg::DATA_W-1:0]  pwdata,
    output logic [rme_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import rme_pkg::*;

    logic [DATA_W-1:0] r_modulus;
    logic [DATA_W-1:0] r_pub_exp;
    logic [DATA_W-1:0] r_priv_exp;
    logic [1:0]        w_reg_idx;
    logic              w_wr;
    t_cmd              w_cmd;
    t_status           w_status;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_wr      = psel & penable & pwrite;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MODULUS_RST;
            r_pub_exp  <= PUB_EXP_RST;
            r_priv_exp <= PRIV_EXP_RST;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_MODULUS:  r_modulus  <= pwdata;
                REG_PUB_EXP:  r_pub_exp  <= pwdata;
                REG_PRIV_EXP: r_priv_exp <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_reg_idx)
            REG_MODULUS:  prdata = r_modulus;
            REG_PUB_EXP:  prdata = r_pub_exp;
            REG_PRIV_EXP: prdata = r_priv_exp;
            default:      prdata = '0;
        endcase
    end

    rme_controller #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rme_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_func         (i_func),
        .i_message      (i_message),
        .i_modulus      (r_modulus),
        .i_pub_exp      (r_pub_exp),
        .i_priv_exp     (r_priv_exp),
        .o_result_value (o_result_value)
    );

endmodule

// ===== bench/rsa_modular_exponentiation_core_test.sv =====
// Self-checking testbench for the RSA modular exponentiation core.
module rsa_modular_exponentiation_core_test;
    import rme_pkg::*;

    // Address that decodes to no register; writes to it must be dropped.
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 4'hC;
    // Worst-case cycles for one word at the default width.
    localparam int WORD_CYCLES = 2200;

    // Tracks the register settings and the results still owed by the core.
    class modexp_scoreboard;
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] pub_exp;
        logic [DATA_W-1:0] priv_exp;
        logic [DATA_W-1:0] expected_q[$];
        int errors;

        function new();
            modulus  = MODULUS_RST;
            pub_exp  = PUB_EXP_RST;
            priv_exp = PRIV_EXP_RST;
            errors   = 0;
        endfunction

        // Indexes outside the register map are ignored, as in the core.
        function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MODULUS:  modulus  = value;
                REG_PUB_EXP:  pub_exp  = value;
                REG_PRIV_EXP: priv_exp = value;
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_MODULUS:  return modulus;
                REG_PUB_EXP:  return pub_exp;
                REG_PRIV_EXP: return priv_exp;
                default:      return '0;
            endcase
        endfunction

        // Right-to-left square and multiply; products of two 32-bit residues fit in 64 bits.
        function logic [DATA_W-1:0] power_mod(logic [DATA_W-1:0] base,
                                              logic [DATA_W-1:0] expo,
                                              logic [DATA_W-1:0] n);
            longint unsigned acc;
            longint unsigned sq;
            longint unsigned nn;
            if (n < 2) return '0;
            nn  = 64'(n);
            acc = 1;
            sq  = 64'(base) % nn;
            for (int i = 0; i < DEF_WIDTH; i++) begin
                if (expo[i]) acc = (acc * sq) % nn;
                sq = (sq * sq) % nn;
            end
            return acc[DATA_W-1:0];
        endfunction

        function void note_word(logic func, logic [DATA_W-1:0] message);
            expected_q.insert(expected_q.size(),
                              power_mod(message,
                                        (func == FUNC_DECRYPT) ? priv_exp : pub_exp,
                                        modulus));
        endfunction

        function void check_result(logic [DATA_W-1:0] actual);
            logic [DATA_W-1:0] want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, actual);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (actual !== want) begin
                $display("%0t: result_value mismatch, expected %h, actual %h",
                         $time, want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic                i_func         = FUNC_ENCRYPT;
    logic [DATA_W-1:0]   i_message      = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [DATA_W-1:0]   o_result_value;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    modexp_scoreboard board = new();

    // Sender and receiver pacing.
    int tx_burst_left = 0;
    bit tx_quiet      = 1'b0;
    int rx_left       = 0;
    bit rx_stall      = 1'b0;
    bit rx_quiet      = 1'b0;

    rsa_modular_exponentiation_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_message      (i_message),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_value (o_result_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the core hangs.
    initial begin
        #150_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: check each accepted word, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) board.check_result(o_result_value);
            if (rx_quiet) begin
                rx_stall = 1'b0;
                rx_left  = 0;
            end else if (rx_left == 0) begin
                rx_stall = !rx_stall;
                if (!rx_stall)
                    rx_left = $urandom_range(1, 200);
                else if ($urandom_range(0, 63) == 0)
                    rx_left = $urandom_range(500, 3000);
                else
                    rx_left = $urandom_range(1, 20);
            end else begin
                rx_left--;
            end
        end
        i_out_stall <= rx_stall;
    end

    // Register write: setup cycle, then access until pready.
    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.set_reg(addr[3:2], value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register read, compared against the shadow copy.
    task automatic reg_check(logic [1:0] idx);
        logic [DATA_W-1:0] want;
        want    = board.reg_value(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                     $time, idx, want, prdata);
            board.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [DATA_W-1:0] n, logic [DATA_W-1:0] e,
                             logic [DATA_W-1:0] d);
        reg_write({REG_MODULUS, 2'b00}, n);
        reg_write({REG_PUB_EXP, 2'b00}, e);
        reg_write({REG_PRIV_EXP, 2'b00}, d);
        reg_check(REG_MODULUS);
        reg_check(REG_PUB_EXP);
        reg_check(REG_PRIV_EXP);
    endtask

    // Offer one word and hold it until taken; bursts end in a random gap unless tx_quiet is set.
    task automatic send_word(logic func, logic [DATA_W-1:0] message);
        int gap;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_message  <= message;
        do @(posedge i_clk); while (o_in_stall);
        board.note_word(func, message);
        if (tx_quiet) return;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
        end else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2500)
                                              : $urandom_range(1, 30);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            tx_burst_left = $urandom_range(0, 6);
        end
    endtask

    // Drop valid and wait until every owed result has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_exponent();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 1);
            1:       return $urandom_range(2, 100);
            2:       return $urandom();
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_message(logic [DATA_W-1:0] n);
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            2:       return (n != 0) ? $urandom() % n : $urandom();
            3:       return $urandom_range(0, 3);
            4:       return n - 1;
            default: return $urandom() | 32'h8000_0000;
        endcase
    endfunction

    initial begin
        logic [DATA_W-1:0] n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset register values, read back and exercised.
        reg_check(REG_MODULUS);
        reg_check(REG_PUB_EXP);
        reg_check(REG_PRIV_EXP);
        send_word(FUNC_ENCRYPT, 32'h0000_0000);
        send_word(FUNC_DECRYPT, 32'h0000_0001);
        send_word(FUNC_ENCRYPT, 32'hFFFF_FFFF);
        send_word(FUNC_DECRYPT, 32'hFFFF_FFFE);
        drain();

        // Modulus of zero and of one both give a zero result.
        reg_write({REG_MODULUS, 2'b00}, 32'd0);
        send_word(FUNC_ENCRYPT, 32'd5);
        send_word(FUNC_DECRYPT, 32'hFFFF_FFFF);
        drain();
        reg_write({REG_MODULUS, 2'b00}, 32'd1);
        send_word(FUNC_ENCRYPT, 32'd7);
        send_word(FUNC_DECRYPT, 32'd0);
        drain();

        // Largest modulus and exponent; a zero exponent gives one.
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_word(FUNC_ENCRYPT, 32'hFFFF_FFFF);
        send_word(FUNC_ENCRYPT, 32'hFFFF_FFFE);
        send_word(FUNC_DECRYPT, 32'h1234_5678);
        send_word(FUNC_ENCRYPT, 32'd1);
        send_word(FUNC_ENCRYPT, 32'd0);
        send_word(FUNC_ENCRYPT, 32'h8000_0000);
        drain();

        // A write outside the register map must leave all registers alone.
        reg_write(ADDR_UNUSED, 32'hDEAD_BEEF);
        reg_check(REG_MODULUS);
        reg_check(REG_PUB_EXP);
        reg_check(REG_PRIV_EXP);

        // Textbook key pair: encrypt then decrypt, messages above the modulus too.
        write_all(32'd3233, 32'd17, 32'd2753);
        send_word(FUNC_ENCRYPT, 32'd65);
        send_word(FUNC_DECRYPT, 32'd2790);
        send_word(FUNC_ENCRYPT, 32'd3232);
        send_word(FUNC_DECRYPT, 32'd3233);
        send_word(FUNC_ENCRYPT, 32'hAAAA_AAAA);
        send_word(FUNC_DECRYPT, 32'h5555_5555);
        drain();

        // Random phases, each with fresh register values.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0:       n = $urandom_range(2, 255);
                1:       n = $urandom() | 32'h8000_0000;
                2:       n = $urandom_range(2, 65535);
                default: n = $urandom();
            endcase
            if (phase == 5) n = $urandom_range(0, 1);
            write_all(n, pick_exponent(), pick_exponent());
            tx_quiet      = (phase == 2 || phase == 6);
            rx_quiet      = tx_quiet;
            tx_burst_left = 0;
            for (int k = 0; k < 35; k++)
                send_word(1'($urandom_range(0, 1)), pick_message(n));
            drain();
        end

        // Let any stray result show up before the verdict.
        repeat (WORD_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
